@@ rtl/pmmwf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-sensor min/max tracker: shared types and constants
// Channel payload structs, table entry layout, command codes and the
// configuration register map.
// ----------------------------------------------------------------------------
package pmmwf_pkg;

   typedef enum logic [1:0] {
      CMD_RECORD = 2'd0,
      CMD_REPORT = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type            command;
      logic [15:0]        sensor_id;
      logic [11:0]        record_year;
      logic signed [15:0] record_value;
   } req_type;

   typedef struct packed {
      logic [15:0]        out_sensor_id;
      logic signed [15:0] min_value;
      logic signed [15:0] max_value;
      logic               in_window;
      logic               entry_valid;
      logic               table_overflow;
      logic               last;
   } rsp_type;

   // One table row as stored in the entry memory.
   typedef struct packed {
      logic [15:0]        id;
      logic signed [15:0] min_value;
      logic signed [15:0] max_value;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Starting point of a fresh entry, in tenths of a unit.
   localparam logic signed [15:0] MIN_START = 16'sd10000;
   localparam logic signed [15:0] MAX_START = -16'sd5000;

   // Configuration register map.
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_YEAR     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WINDOW_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WINDOW_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WINDOW_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WINDOW_HIGH = 3'd4;

endpackage

@@ rtl/pmmwf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// its value while no read is enabled.
// ----------------------------------------------------------------------------
module pmmwf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/per_sensor_min_max_window_flag_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-sensor minimum/maximum tracker with window flag
// Keeps a running min and max per sensor id in a RAM table and reports
// the table with a window flag per entry.
// ----------------------------------------------------------------------------
// The block works on one command at a time. A record of the configured year
// scans the stored ids through the single read port of the entry RAM, one id
// per cycle, and then writes the updated or newly created row back, or flags
// the overflow when the table is full. A report streams one entry per cycle
// out of the same read port while the result side does not stall; an
// empty table gives a single item with entry_valid low. The result register
// decouples the two sides, so a waiting result only holds back a new report,
// not records or clears. The table rows have no reset value; only rows below
// the fill count are ever read, so no clearing pass is needed after reset.
// Configuration registers must only be written while the block is idle.
// ----------------------------------------------------------------------------
module per_sensor_min_max_window_flag_core #(
   parameter int MAX_SENSORS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Command channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  pmmwf_pkg::req_type                   req_data,
   // Result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output pmmwf_pkg::rsp_type                   rsp_data,
   // Configuration write port
   input  logic                                 csr_we,
   input  logic [pmmwf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pmmwf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import pmmwf_pkg::*;

   localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
   localparam int CNT_W = $clog2(MAX_SENSORS + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_REPORT = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               overflow_ff, overflow_in;

   logic [11:0]        target_year_ff;
   logic signed [15:0] min_low_ff, min_high_ff, max_low_ff, max_high_ff;

   logic [15:0]        cur_id_ff, cur_id_in;
   logic signed [15:0] cur_val_ff, cur_val_in;

   // Scan pointer: next row to read. The compare stage holds the row whose
   // read data is on the RAM output this cycle.
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   entry_type          ram_wr_entry;
   logic               ram_rd_en;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type          rd_entry;

   logic               req_accept;
   logic               year_match;
   logic               id_hit;
   logic               table_full;
   logic               more_rows;
   logic               load_rsp;
   logic               in_window;

   pmmwf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_SENSORS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = entry_type'(ram_rd_data);

   // A report needs the result register, so it waits while a result is stuck.
   assign req_stall  = (state_ff != ST_IDLE) ||
                       (rsp_valid_ff && rsp_stall && (req_data.command == CMD_REPORT));
   assign req_accept = req_valid && !req_stall;
   assign year_match = (req_data.record_year == target_year_ff);

   assign id_hit     = cmp_valid_ff && (rd_entry.id == cur_id_ff);
   assign more_rows  = (rd_idx_ff < count_ff);
   assign table_full = (count_ff == CNT_W'(MAX_SENSORS));
   assign load_rsp   = cmp_valid_ff && (!rsp_valid_ff || !rsp_stall);

   // Both windows are inclusive; a window with low above high never matches.
   assign in_window = ((rd_entry.min_value >= min_low_ff) &&
                       (rd_entry.min_value <= min_high_ff)) ||
                      ((rd_entry.max_value >= max_low_ff) &&
                       (rd_entry.max_value <= max_high_ff));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      cur_id_in    = cur_id_ff;
      cur_val_in   = cur_val_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cmp_idx_ff;
      ram_wr_entry.id        = cur_id_ff;
      ram_wr_entry.min_value = (cur_val_ff < rd_entry.min_value) ? cur_val_ff
                                                                 : rd_entry.min_value;
      ram_wr_entry.max_value = (cur_val_ff > rd_entry.max_value) ? cur_val_ff
                                                                 : rd_entry.max_value;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.command)
                  CMD_RECORD: begin
                     if (year_match) begin
                        cur_id_in    = req_data.sensor_id;
                        cur_val_in   = req_data.record_value;
                        rd_idx_in    = '0;
                        cmp_valid_in = 1'b0;
                        state_in     = ST_SEARCH;
                     end
                  end
                  CMD_REPORT: begin
                     if (count_ff == '0) begin
                        rsp_valid_in                = 1'b1;
                        rsp_data_in                 = '0;
                        rsp_data_in.table_overflow  = overflow_ff;
                        rsp_data_in.last            = 1'b1;
                     end else begin
                        rd_idx_in    = '0;
                        cmp_valid_in = 1'b0;
                        state_in     = ST_REPORT;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in    = '0;
                     overflow_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SEARCH: begin
            if (id_hit) begin
               // Known sensor: fold the value into the stored min and max.
               ram_wr_en = 1'b1;
               state_in  = ST_IDLE;
            end else if (more_rows) begin
               ram_rd_en    = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = rd_idx_ff[IDX_W-1:0];
               rd_idx_in    = rd_idx_ff + CNT_W'(1);
            end else begin
               // New sensor: append a row, or flag the overflow when full.
               if (table_full) begin
                  overflow_in = 1'b1;
               end else begin
                  ram_wr_en              = 1'b1;
                  ram_wr_addr            = count_ff[IDX_W-1:0];
                  ram_wr_entry.min_value = (cur_val_ff < MIN_START) ? cur_val_ff : MIN_START;
                  ram_wr_entry.max_value = (cur_val_ff > MAX_START) ? cur_val_ff : MAX_START;
                  count_in               = count_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end

         ST_REPORT: begin
            if (load_rsp) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.out_sensor_id   = rd_entry.id;
               rsp_data_in.min_value       = rd_entry.min_value;
               rsp_data_in.max_value       = rd_entry.max_value;
               rsp_data_in.in_window       = in_window;
               rsp_data_in.entry_valid     = 1'b1;
               rsp_data_in.table_overflow  = overflow_ff;
               rsp_data_in.last            = ((CNT_W'(cmp_idx_ff) + CNT_W'(1)) == count_ff);
            end
            if (more_rows && (!cmp_valid_ff || load_rsp)) begin
               ram_rd_en    = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = rd_idx_ff[IDX_W-1:0];
               rd_idx_in    = rd_idx_ff + CNT_W'(1);
            end else if (load_rsp) begin
               cmp_valid_in = 1'b0;
            end
            if (!more_rows && (!cmp_valid_ff || load_rsp)) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         overflow_ff    <= 1'b0;
         cmp_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         target_year_ff <= 12'd0;
         min_low_ff     <= -16'sd40;
         min_high_ff    <= -16'sd20;
         max_low_ff     <= 16'sd500;
         max_high_ff    <= 16'sd690;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TARGET_YEAR:     target_year_ff <= csr_wdata[11:0];
               CSR_MIN_WINDOW_LOW:  min_low_ff     <= csr_wdata;
               CSR_MIN_WINDOW_HIGH: min_high_ff    <= csr_wdata;
               CSR_MAX_WINDOW_LOW:  max_low_ff     <= csr_wdata;
               CSR_MAX_WINDOW_HIGH: max_high_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      cur_id_ff   <= cur_id_in;
      cur_val_ff  <= cur_val_in;
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/pmmwf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-sensor min/max tracker: port checker
// Watches the top level ports and flags result sequences the block must
// never produce.
// ----------------------------------------------------------------------------
module pmmwf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input pmmwf_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input pmmwf_pkg::rsp_type rsp_data
);

   import pmmwf_pkg::*;

   // A stalled result stays put until it is transferred.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // The empty-table item is the whole report and carries zero data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.entry_valid |->
         rsp_data.last && (rsp_data.out_sensor_id == 16'd0) &&
         (rsp_data.min_value == 16'sd0) && (rsp_data.max_value == 16'sd0) &&
         !rsp_data.in_window)
      else $error("malformed empty-table item");

   // Only a report transfer can start a new result.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.command != CMD_REPORT) |=> !$rose(rsp_valid))
      else $error("result appeared after a non-report command");

   // No result is pending right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind per_sensor_min_max_window_flag_core pmmwf_checker u_pmmwf_checker (.*);

@@ dv/tb_per_sensor_min_max_window_flag_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the per-sensor min/max tracker with window flag
// Drives record, report, clear and unused commands through the valid/stall
// command channel, predicts every report line in a cycle-free table model
// and checks each result transfer field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_per_sensor_min_max_window_flag_core;
   import pmmwf_pkg::*;

   localparam int MAX_SENSORS  = 32;
   // A record may scan the whole table before it writes back, so the block may
   // still be busy with one after the last report line.
   localparam int DRAIN_CYCLES = MAX_SENSORS + 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 200000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_valid  = 1'b0;
   logic                  req_stall;
   req_type               req_data   = '0;
   logic                  rsp_valid;
   logic                  rsp_stall  = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   per_sensor_min_max_window_flag_core #(
      .MAX_SENSORS(MAX_SENSORS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Table model. It mirrors the configuration registers and the sensor table
   // and turns every accepted command into the report lines it must produce.
   // -------------------------------------------------------------------------
   logic [11:0]        cfg_year;
   logic signed [15:0] cfg_min_lo;
   logic signed [15:0] cfg_min_hi;
   logic signed [15:0] cfg_max_lo;
   logic signed [15:0] cfg_max_hi;

   logic [15:0]        tbl_id  [MAX_SENSORS];
   logic signed [15:0] tbl_min [MAX_SENSORS];
   logic signed [15:0] tbl_max [MAX_SENSORS];
   int                 tbl_count;
   logic               tbl_overflow;

   rsp_type report_lines_due[$];
   req_type commands_pending[$];

   // Bookkeeping shared between the processes.
   int   fault_count    = 0;
   int   commands_taken = 0;
   int   lines_checked  = 0;
   int   flagged_lines  = 0;
   int   overflow_lines = 0;
   int   cycle_count    = 0;
   bit   steady         = 1'b0;   // no idling on either side while set
   int   holds_asked    = 0;
   int   holds_done     = 0;
   int   hold_left      = 0;
   bit   req_took       = 1'b0;
   logic [15:0] id_base = 16'h0100;

   function automatic void track_sensor_command(req_type cmd);
      int      slot;
      rsp_type line;
      case (cmd.command)
         CMD_RECORD: begin
            if (cmd.record_year != cfg_year) return;
            slot = tbl_count;
            for (int i = 0; i < tbl_count; i++) begin
               if (tbl_id[i] == cmd.sensor_id) begin
                  slot = i;
                  break;
               end
            end
            if (slot == tbl_count) begin
               // Table full: the new id is dropped and remembered as overflow.
               if (tbl_count >= MAX_SENSORS) begin
                  tbl_overflow = 1'b1;
                  return;
               end
               tbl_id[slot]  = cmd.sensor_id;
               tbl_min[slot] = MIN_START;
               tbl_max[slot] = MAX_START;
               tbl_count++;
            end
            if (cmd.record_value < tbl_min[slot]) tbl_min[slot] = cmd.record_value;
            if (cmd.record_value > tbl_max[slot]) tbl_max[slot] = cmd.record_value;
         end
         CMD_CLEAR: begin
            tbl_count    = 0;
            tbl_overflow = 1'b0;
         end
         CMD_REPORT: begin
            if (tbl_count == 0) begin
               // An empty table still answers with one line marked not valid.
               line                = '0;
               line.table_overflow = tbl_overflow;
               line.last           = 1'b1;
               report_lines_due.push_back(line);
               return;
            end
            for (int i = 0; i < tbl_count; i++) begin
               line.out_sensor_id  = tbl_id[i];
               line.min_value      = tbl_min[i];
               line.max_value      = tbl_max[i];
               // Windows are inclusive; a window with low above high never hits.
               line.in_window      = (tbl_min[i] >= cfg_min_lo && tbl_min[i] <= cfg_min_hi) ||
                                     (tbl_max[i] >= cfg_max_lo && tbl_max[i] <= cfg_max_hi);
               line.entry_valid    = 1'b1;
               line.table_overflow = tbl_overflow;
               line.last           = (i == tbl_count - 1);
               report_lines_due.push_back(line);
            end
         end
         default: ;   // the unused command leaves everything alone
      endcase
   endfunction

   function automatic req_type make_req(cmd_type cmd, logic [15:0] id, logic [11:0] year,
                                        logic signed [15:0] value);
      req_type r;
      r.command      = cmd;
      r.sensor_id    = id;
      r.record_year  = year;
      r.record_value = value;
      return r;
   endfunction

   // Values cluster around the window bounds and the fresh-entry start values
   // so that the inclusive edges and the start clamps are hit often.
   function automatic logic signed [15:0] pick_value();
      logic signed [15:0] bound;
      case ($urandom_range(3))
         0: begin
            case ($urandom_range(3))
               0: bound = cfg_min_lo;
               1: bound = cfg_min_hi;
               2: bound = cfg_max_lo;
               default: bound = cfg_max_hi;
            endcase
            return 16'(int'(bound) + int'($urandom_range(4)) - 2);
         end
         1: return ($urandom_range(1) != 0) ? MIN_START + 16'sd1 : MAX_START - 16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly records of the counted year over a small id pool, so entries get
   // updated many times; the rest is other years, reports, clears and noise.
   function automatic req_type random_command();
      int          roll;
      logic [15:0] id;
      roll = $urandom_range(99);
      id   = ($urandom_range(9) == 0) ? 16'($urandom) : id_base + 16'($urandom_range(11));
      if (roll < 70) return make_req(CMD_RECORD, id, cfg_year, pick_value());
      if (roll < 80) return make_req(CMD_RECORD, id, 12'($urandom), 16'($urandom));
      if (roll < 92) return make_req(CMD_REPORT, 16'($urandom), 12'($urandom), 16'($urandom));
      if (roll < 96) return make_req(CMD_CLEAR, 16'($urandom), 12'($urandom), 16'($urandom));
      return make_req(CMD_UNUSED, 16'($urandom), 12'($urandom), 16'($urandom));
   endfunction

   // -------------------------------------------------------------------------
   // Command driver. A new transfer is offered only once the previous one was
   // taken; a stalled payload stays as it is. Inputs move on the falling edge.
   // -------------------------------------------------------------------------
   logic    next_valid;
   req_type next_data;

   always @(negedge clock) begin
      next_valid = req_valid;
      next_data  = req_data;
      if (!reset && (!req_valid || req_took)) begin
         next_valid = 1'b0;
         if (commands_pending.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
            next_data  = commands_pending.pop_front();
            next_valid = 1'b1;
         end
      end
      req_valid <= next_valid;
      req_data  <= next_data;
   end

   // Result receiver. A requested hold-off is counted here, in cycles, so the
   // block fills up and must push back on the command side.
   always @(negedge clock) begin
      if (holds_done < holds_asked) begin
         hold_left = HOLD_CYCLES;
         holds_done++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 30);
      end
   end

   // -------------------------------------------------------------------------
   // Monitor. Both channels are sampled on the rising edge. Accepted commands
   // feed the model; accepted results are checked against the oldest line due.
   // -------------------------------------------------------------------------
   rsp_type want;

   task automatic check_field(string field_name, int want_v, int got_v);
      if (want_v != got_v) begin
         fault_count++;
         $display("%0t: mismatch on %s: expected %0d, actual %0d",
                  $time, field_name, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      req_took = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_took = 1'b1;
            commands_taken++;
            track_sensor_command(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (report_lines_due.size() == 0) begin
               fault_count++;
               $display("%0t: mismatch: unexpected result, expected none, actual id %0d",
                        $time, rsp_data.out_sensor_id);
            end else begin
               want = report_lines_due.pop_front();
               check_field("out_sensor_id", want.out_sensor_id, rsp_data.out_sensor_id);
               check_field("min_value", int'(want.min_value), int'(rsp_data.min_value));
               check_field("max_value", int'(want.max_value), int'(rsp_data.max_value));
               check_field("in_window", want.in_window, rsp_data.in_window);
               check_field("entry_valid", want.entry_valid, rsp_data.entry_valid);
               check_field("table_overflow", want.table_overflow, rsp_data.table_overflow);
               check_field("last", want.last, rsp_data.last);
               lines_checked++;
               if (want.in_window) flagged_lines++;
               if (want.table_overflow) overflow_lines++;
            end
         end
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d result lines still due",
                  $time, cycle_count, report_lines_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sequencing
   // -------------------------------------------------------------------------

   // Registers are written only while the block is idle; the model copy
   // follows at the same edge.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      case (idx)
         CSR_TARGET_YEAR:     cfg_year   = value[11:0];
         CSR_MIN_WINDOW_LOW:  cfg_min_lo = value;
         CSR_MIN_WINDOW_HIGH: cfg_min_hi = value;
         CSR_MAX_WINDOW_LOW:  cfg_max_lo = value;
         CSR_MAX_WINDOW_HIGH: cfg_max_hi = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // The sender pauses here until every line due has arrived, then gives a
   // trailing record scan time to finish before anything else happens.
   task automatic wait_quiet();
      while (commands_pending.size() != 0 || req_valid || report_lines_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      cfg_year     = 12'd0;
      cfg_min_lo   = -16'sd40;
      cfg_min_hi   = -16'sd20;
      cfg_max_lo   = 16'sd500;
      cfg_max_hi   = 16'sd690;
      tbl_count    = 0;
      tbl_overflow = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset configuration: empty table, ignored
      // years, field extremes, inclusive window edges, start value clamps,
      // the unused command, and a clear followed by an empty report.
      commands_pending.push_back(make_req(CMD_REPORT, 16'h0000, 12'd0, 0));
      commands_pending.push_back(make_req(CMD_RECORD, 16'h0001, 12'd1, 0));
      commands_pending.push_back(make_req(CMD_RECORD, 16'h0000, 12'd0, -32768));
      commands_pending.push_back(make_req(CMD_RECORD, 16'hFFFF, 12'd0, 32767));
      commands_pending.push_back(make_req(CMD_RECORD, 16'h1234, 12'd0, -30));
      commands_pending.push_back(make_req(CMD_RECORD, 16'h1234, 12'd0, 600));
      commands_pending.push_back(make_req(CMD_RECORD, 16'd5, 12'd0, -40));
      commands_pending.push_back(make_req(CMD_RECORD, 16'd6, 12'd0, -20));
      commands_pending.push_back(make_req(CMD_RECORD, 16'd7, 12'd0, 500));
      commands_pending.push_back(make_req(CMD_RECORD, 16'd8, 12'd0, 690));
      commands_pending.push_back(make_req(CMD_RECORD, 16'd9, 12'd0, -41));
      commands_pending.push_back(make_req(CMD_RECORD, 16'd10, 12'd0, 691));
      commands_pending.push_back(make_req(CMD_RECORD, 16'd11, 12'd0, 10001));
      commands_pending.push_back(make_req(CMD_RECORD, 16'd12, 12'd0, -5001));
      commands_pending.push_back(make_req(CMD_RECORD, 16'd13, 12'd0, 10000));
      commands_pending.push_back(make_req(CMD_UNUSED, 16'hFFFF, 12'hFFF, -1));
      commands_pending.push_back(make_req(CMD_REPORT, 16'hFFFF, 12'hFFF, -1));
      commands_pending.push_back(make_req(CMD_CLEAR, 16'hFFFF, 12'hFFF, -1));
      commands_pending.push_back(make_req(CMD_REPORT, 16'h0000, 12'd0, 0));
      commands_pending.push_back(make_req(CMD_RECORD, 16'hFFFF, 12'hFFF, 5));
      commands_pending.push_back(make_req(CMD_REPORT, 16'h0000, 12'd0, 0));
      wait_quiet();

      // Extreme settings: the top year, a min window that takes every value
      // and a max window that can never match. No idling on either side.
      write_csr(CSR_TARGET_YEAR, 16'h0FFF);
      write_csr(CSR_MIN_WINDOW_LOW, 16'h8000);
      write_csr(CSR_MIN_WINDOW_HIGH, 16'h7FFF);
      write_csr(CSR_MAX_WINDOW_LOW, 16'h7FFF);
      write_csr(CSR_MAX_WINDOW_HIGH, 16'h8000);
      id_base = 16'($urandom);
      steady  = 1'b1;
      repeat (30) commands_pending.push_back(random_command());
      commands_pending.push_back(make_req(CMD_REPORT, 16'h0000, 12'd0, 0));
      wait_quiet();
      steady = 1'b0;

      // A random year, an empty min window and a max window that covers the
      // fresh-entry start. The receiver holds off while reports pile up.
      write_csr(CSR_TARGET_YEAR, 16'($urandom_range(4094, 1)));
      write_csr(CSR_MIN_WINDOW_LOW, 16'd20);
      write_csr(CSR_MIN_WINDOW_HIGH, -16'sd20);
      write_csr(CSR_MAX_WINDOW_LOW, -16'sd5000);
      write_csr(CSR_MAX_WINDOW_HIGH, 16'd200);
      id_base = 16'($urandom);
      holds_asked++;
      repeat (3) commands_pending.push_back(make_req(CMD_REPORT, 16'h0000, 12'd0, 0));
      repeat (30) commands_pending.push_back(random_command());
      commands_pending.push_back(make_req(CMD_REPORT, 16'h0000, 12'd0, 0));
      wait_quiet();

      // Year zero again: fill the table past its size so a new id is dropped,
      // show the overflow in the report, then clear it and carry on at random.
      write_csr(CSR_TARGET_YEAR, 16'd0);
      write_csr(CSR_MIN_WINDOW_LOW, -16'sd100);
      write_csr(CSR_MIN_WINDOW_HIGH, 16'd100);
      write_csr(CSR_MAX_WINDOW_LOW, 16'd32767);
      write_csr(CSR_MAX_WINDOW_HIGH, 16'd32767);
      id_base = 16'($urandom);
      commands_pending.push_back(make_req(CMD_CLEAR, 16'h0000, 12'd0, 0));
      for (int k = 0; k < MAX_SENSORS + 2; k++)
         commands_pending.push_back(make_req(CMD_RECORD, id_base + 16'(k), 12'd0, pick_value()));
      commands_pending.push_back(make_req(CMD_RECORD, id_base, 12'd0, 16'd32767));
      commands_pending.push_back(make_req(CMD_REPORT, 16'h0000, 12'd0, 0));
      commands_pending.push_back(make_req(CMD_CLEAR, 16'h0000, 12'd0, 0));
      commands_pending.push_back(make_req(CMD_REPORT, 16'h0000, 12'd0, 0));
      repeat (30) commands_pending.push_back(random_command());
      commands_pending.push_back(make_req(CMD_REPORT, 16'h0000, 12'd0, 0));
      wait_quiet();

      $display("Covered %0d commands and %0d report lines (%0d flagged, %0d with overflow).",
               commands_taken, lines_checked, flagged_lines, overflow_lines);
      $display("Settings: reset windows, all-pass and empty windows, years 0 and 4095, %s",
               "a full table and a long result hold-off.");
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
